// ----- hdl/aes_pkg.sv -----
//------------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box, round constants and round helper functions.
//------------------------------------------------------------------------------
package aes_pkg;

	localparam int NumRounds = 10;

	localparam logic [1:0] RegKeyHigh = 2'd0;
	localparam logic [1:0] RegKeyLow  = 2'd1;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
	} aes_in_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} aes_out_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte n of a 128-bit state sits at bits 127-8n : 120-8n.
	function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
		get_byte = s[127 - 8*n -: 8];
	endfunction

	function automatic logic [127:0] next_round_key(input logic [127:0] k,
			input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] w0, w1, w2, w3;
		t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w0 = k[127:96] ^ t;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		next_round_key = {w0, w1, w2, w3};
	endfunction

	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8*(c*4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4)*4 + r)];
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, al;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, c*4);
			a1 = get_byte(s, c*4 + 1);
			a2 = get_byte(s, c*4 + 2);
			a3 = get_byte(s, c*4 + 3);
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 8*(c*4)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[127 - 8*(c*4 + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[127 - 8*(c*4 + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[127 - 8*(c*4 + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		mix_columns = t;
	endfunction

endpackage

// ----- hdl/aes_round.sv -----
//------------------------------------------------------------------------------
// AES round stage
// One registered round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey,
// with the next round key expanded alongside.
//------------------------------------------------------------------------------
module aes_round
	import aes_pkg::*;
#(
	parameter logic [7:0] Rc = 8'h01,
	parameter bit Last = 1'b0
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_in,
	input  logic [127:0] state_in,
	input  logic [127:0] key_in,
	output logic         valid_out,
	output logic [127:0] state_out,
	output logic [127:0] key_out
);

	logic [127:0] key_nx;
	logic [127:0] sb;
	logic [127:0] mx;

	always_comb begin
		key_nx = next_round_key(key_in, Rc);
		sb = sub_shift(state_in);
		mx = Last ? sb : mix_columns(sb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		state_out <= mx ^ key_nx;
		key_out <= key_nx;
	end

endmodule

// ----- hdl/aes128_block_encrypt.sv -----
//------------------------------------------------------------------------------
// AES-128 block encryption
// Fully unrolled pipeline: one input register with the initial AddRoundKey,
// then ten round stages, each expanding its round key on the fly.
//------------------------------------------------------------------------------
// Channel   Signals                        Direction
// input     start, data_in                 in; busy is out and always low
// result    done, data_out                 out, one-cycle strobe
// config    cfg_we, cfg_index, cfg_data    in, write only
//
// A block transfer is taken every cycle; its result passes through eleven register
// stages (input plus ten rounds) before it appears on data_out.
// Reset clears the valid bits and both key registers to zero.
// The receiver cannot stall, so the pipeline never holds.
//------------------------------------------------------------------------------
module aes128_block_encrypt
	import aes_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  aes_in_t      data_in,
	output logic         done,
	output aes_out_t     data_out,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	logic [63:0] key_high_q, key_low_q;
	logic valid_s0;
	logic [127:0] state_s0, key_s0;
	logic [NumRounds:0] vld;
	logic [127:0] st [NumRounds+1];
	logic [127:0] rk [NumRounds+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start;
			if (cfg_we) begin
				unique case (cfg_index)
					RegKeyHigh: key_high_q <= cfg_data;
					RegKeyLow:  key_low_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		state_s0 <= {data_in.block_high, data_in.block_low} ^ {key_high_q, key_low_q};
		key_s0 <= {key_high_q, key_low_q};
	end

	assign vld[0] = valid_s0;
	assign st[0] = state_s0;
	assign rk[0] = key_s0;

	for (genvar i = 0; i < NumRounds; i++) begin : g_round
		aes_round #(
			.Rc(RCON[i]),
			.Last(i == NumRounds - 1)
		) u_round (
			.clk(clk),
			.arst_n(arst_n),
			.valid_in(vld[i]),
			.state_in(st[i]),
			.key_in(rk[i]),
			.valid_out(vld[i+1]),
			.state_out(st[i+1]),
			.key_out(rk[i+1])
		);
	end

	assign done = vld[NumRounds];
	assign data_out.cipher_high = st[NumRounds][127:64];
	assign data_out.cipher_low = st[NumRounds][63:0];

endmodule

// ----- hdl/aes_checker.sv -----
//------------------------------------------------------------------------------
// AES-128 port checker
// Checks the port behavior of the encryption pipeline over time.
//------------------------------------------------------------------------------
module aes_checker
	import aes_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input logic     done
);

	localparam int Latency = NumRounds + 1;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##Latency done)
		else $error("missing result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##Latency !done)
		else $error("spurious result");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done)
);
